FILE: rtl/gsdu_pkg.sv
// Shared types and constants for the GCR sector data unscrambler.
package gsdu_pkg;

  localparam int unsigned NibbleW   = 6;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned SumW      = 9;
  localparam int unsigned PosW      = 10;

  // Sector layout: 174 full groups of four, one short group, four checks.
  localparam int unsigned NumGroups = 174;
  localparam logic [PosW-1:0] DataValues   = PosW'(4 * NumGroups + 3);
  localparam logic [PosW-1:0] SectorValues = PosW'(4 * NumGroups + 7);
  localparam logic [PosW-1:0] CheckTopPos  = DataValues;
  localparam logic [PosW-1:0] CheckCPos    = PosW'(4 * NumGroups + 4);
  localparam logic [PosW-1:0] CheckBPos    = PosW'(4 * NumGroups + 5);
  localparam logic [PosW-1:0] CheckAPos    = PosW'(4 * NumGroups + 6);

  // Place of a value within its group.
  typedef enum logic [1:0] {
    SlotTop = 2'd0,
    SlotA   = 2'd1,
    SlotB   = 2'd2,
    SlotC   = 2'd3
  } slot_e;

  typedef struct packed {
    logic [NibbleW-1:0] nibble;
    logic               start_req;
  } in_item_t;

  typedef struct packed {
    logic             is_status;
    logic [ByteW-1:0] data_byte;
    logic             checksum_ok;
    logic             last;
  } out_item_t;

endpackage

FILE: rtl/gsdu_stream_if.sv
// Valid/ready stream interface carrying one payload struct per transfer.
interface gsdu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/gsdu_in_stage.sv
// Input register: captures one incoming value and holds it until the core takes it.
module gsdu_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  gsdu_stream_if.sink         in_i,
  input  logic                advance_i,
  output logic                valid_o,
  output gsdu_pkg::in_item_t  item_o
);
  import gsdu_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;
  assign valid_d    = take ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_i.data;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

FILE: rtl/gsdu_core.sv
// Sector state and unscramble logic: rebuilds bytes, updates the running sums, checks.
module gsdu_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  gsdu_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output gsdu_pkg::out_item_t res_o
);
  import gsdu_pkg::*;

  logic [SumW-1:0]    sum_a_q, sum_a_d, sum_b_q, sum_b_d, sum_c_q, sum_c_d;
  logic [NibbleW-1:0] top_q, top_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               match_q, match_d;

  // Values seen after an optional start-of-sector clear
  logic [SumW-1:0]    sa, sb, sc;
  logic [NibbleW-1:0] top;
  logic [PosW-1:0]    pos;
  logic               match;
  logic [ByteW-1:0]   byte_in, val;
  logic [NibbleW-1:0] expected;
  logic               match_next;
  slot_e              slot;

  always_comb begin
    sa    = item_i.start_req ? '0 : sum_a_q;
    sb    = item_i.start_req ? '0 : sum_b_q;
    sc    = item_i.start_req ? '0 : sum_c_q;
    top   = item_i.start_req ? '0 : top_q;
    pos   = item_i.start_req ? '0 : pos_q;
    match = item_i.start_req ? 1'b1 : match_q;
  end

  assign slot = slot_e'(pos[1:0]);

  always_comb begin
    unique case (pos)
      CheckTopPos: expected = {sc[7:6], sb[7:6], sa[7:6]};
      CheckCPos:   expected = sc[5:0];
      CheckBPos:   expected = sb[5:0];
      default:     expected = sa[5:0];
    endcase
  end

  assign match_next = match && (item_i.nibble == expected);

  always_comb begin
    sum_a_d     = sa;
    sum_b_d     = sb;
    sum_c_d     = sc;
    top_d       = top;
    pos_d       = pos;
    match_d     = match;
    byte_in     = '0;
    val         = '0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (pos < SectorValues) begin
      pos_d = pos + PosW'(1);
      if (pos < DataValues) begin
        unique case (slot)
          SlotTop: begin
            top_d = item_i.nibble;
          end
          SlotA: begin
            // Rotate sum_a left through its byte; the carry feeds sum_c
            byte_in = {top[5:4], item_i.nibble};
            val     = byte_in ^ {sa[6:0], sa[7]};
            sum_a_d = {1'b0, sa[6:0], sa[7]};
            sum_c_d = sc + SumW'(val) + SumW'(sa[7]);
          end
          SlotB: begin
            byte_in = {top[3:2], item_i.nibble};
            val     = byte_in ^ sc[7:0];
            sum_b_d = sb + SumW'(val) + SumW'(sc[8]);
            sum_c_d = {1'b0, sc[7:0]};
          end
          SlotC: begin
            byte_in = {top[1:0], item_i.nibble};
            val     = byte_in ^ sb[7:0];
            sum_a_d = sa + SumW'(val) + SumW'(sb[8]);
            sum_b_d = {1'b0, sb[7:0]};
          end
          default: begin
            top_d = top;
          end
        endcase
        res_valid_o     = (slot != SlotTop);
        res_o.data_byte = val;
      end else begin
        match_d = match_next;
        if (pos == CheckAPos) begin
          res_valid_o       = 1'b1;
          res_o.is_status   = 1'b1;
          res_o.checksum_ok = match_next;
          res_o.last        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q <= '0;
      sum_b_q <= '0;
      sum_c_q <= '0;
      top_q   <= '0;
      pos_q   <= '0;
      match_q <= 1'b1;
    end else if (step_i) begin
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      sum_c_q <= sum_c_d;
      top_q   <= top_d;
      pos_q   <= pos_d;
      match_q <= match_d;
    end
  end
endmodule

FILE: rtl/gsdu_out_stage.sv
// Result register: holds one result until the downstream side takes it.
module gsdu_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  gsdu_pkg::out_item_t item_i,
  output logic                free_o,
  gsdu_stream_if.source       out_o
);
  import gsdu_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = item_q;
endmodule

FILE: rtl/gcr_sector_data_unscramble.sv
// Top level of the GCR 6-and-2 sector data unscrambler.
// Takes one decoded 6-bit value per transfer, 703 per sector (start_req marks the
// first), and returns 524 unscrambled data bytes followed by one status result that
// carries checksum_ok and last. One value is accepted every clock cycle; each
// result is offered on out_o once its value has passed the input register and then
// the result register. The rate is set by the update of the three running sums, which
// each value reads and writes. Top-bits values, the first three check values and
// values past the end of a sector produce no result.
// Backpressure on the result side stalls the input once both registers are full.
module gcr_sector_data_unscramble (
  input  logic        clk_i,
  input  logic        rst_ni,
  gsdu_stream_if.sink   in_i,
  gsdu_stream_if.source out_o
);
  import gsdu_pkg::*;

  logic      s1_valid;
  in_item_t  s1_item;
  logic      out_free;
  logic      advance;
  logic      step;
  logic      res_valid;
  out_item_t res;

  assign advance = out_free;
  assign step    = s1_valid && advance;

  gsdu_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  gsdu_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (s1_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  gsdu_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step && res_valid),
    .item_i (res),
    .free_o (out_free),
    .out_o  (out_o)
  );
endmodule
